// File: src/rop_pkg.sv
// Shared types and constants for the rectangle overlap push vector unit.
// Used by rop_cordic and rect_overlap_push_vector_unit; depends on nothing.
`timescale 1ns / 1ps

package rop_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_GAIN  = 9949;
  // Prep stage, one stage per rotation step, and the quadrant map stage.
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

  localparam int TW = 17;  // cos and sin, Q1.14 with headroom
  localparam int ZW = 16;  // residual angle
  localparam int PRW = 33; // trig times a size
  localparam int CTW = 31; // center scaled to corner units
  localparam int CW = 36;  // corner coordinate
  localparam int MW = 53;  // corner times normal component
  localparam int PW = 56;  // projection
  localparam int LW = 58;  // overlap length
  localparam int LOW = 29; // low slice of the length for the split multiply
  localparam int OUT_SHIFT = 43;

  typedef logic signed [TW-1:0] trig_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } rect_t;

  typedef struct packed {
    rect_t a;
    rect_t b;
  } pair_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
    logic  use_w;
    logic  use_h;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 16'sd8192;
      1:       r = 16'sd4836;
      2:       r = 16'sd2555;
      3:       r = 16'sd1297;
      4:       r = 16'sd651;
      5:       r = 16'sd326;
      6:       r = 16'sd163;
      7:       r = 16'sd81;
      8:       r = 16'sd41;
      9:       r = 16'sd20;
      10:      r = 16'sd10;
      11:      r = 16'sd5;
      12:      r = 16'sd3;
      default: r = 16'sd1;
    endcase
    return r;
  endfunction

endpackage

// File: src/rop_cordic.sv
// Pipelined rotation-mode CORDIC giving cos and sin of a binary angle.
// One rotation step per stage; depends on rop_pkg.
`timescale 1ns / 1ps

module rop_cordic (
  input  logic                clk_i,
  input  logic [15:0]         angle_i,
  output rop_pkg::trig_t      cos_o,
  output rop_pkg::trig_t      sin_o
);

  localparam int N = rop_pkg::CORDIC_STEPS;

  rop_pkg::trig_t                  x_q [0:N];
  rop_pkg::trig_t                  y_q [0:N];
  logic signed [rop_pkg::ZW-1:0]   z_q [0:N];
  logic [1:0]                      quad_q [0:N];
  rop_pkg::trig_t                  cos_q, sin_q;
  logic [15:0]                     t;

  // Rotating by an eighth of a turn puts the residual in [-1/8, 1/8) turn.
  assign t = angle_i + 16'd8192;

  always_ff @(posedge clk_i) begin
    x_q[0]    <= rop_pkg::TW'(rop_pkg::CORDIC_GAIN);
    y_q[0]    <= '0;
    z_q[0]    <= $signed({2'b00, t[13:0]}) - 16'sd8192;
    quad_q[0] <= t[15:14];
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      quad_q[i+1] <= quad_q[i];
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - rop_pkg::atan_step(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + rop_pkg::atan_step(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (quad_q[N])
      2'd0: begin
        cos_q <= x_q[N];
        sin_q <= y_q[N];
      end
      2'd1: begin
        cos_q <= -y_q[N];
        sin_q <= x_q[N];
      end
      2'd2: begin
        cos_q <= -x_q[N];
        sin_q <= -y_q[N];
      end
      default: begin
        cos_q <= y_q[N];
        sin_q <= -x_q[N];
      end
    endcase
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// File: src/rect_overlap_push_vector_unit.sv
// Top level of the rectangle overlap push vector unit.
// Depends on rop_pkg and rop_cordic.
`timescale 1ns / 1ps

// Usage:
// A request carries two rotated rectangles (center, width, height, angle).
// It is taken at a rising edge where start is high and busy is low; busy is
// always low, so a new request may enter every cycle.
// The result (overlap flag and push vector) appears on the result ports for
// exactly one cycle with done_o high, after the request has passed through
// the two CORDIC pipelines (one rotation step per stage), then through
// nine stages for corners, projections, per-axis overlap, axis selection
// and the split final multiply with rounding and saturation.
// Throughput is one request per cycle; results leave in request order.
// The push is zero when an axis of the second rectangle separates the pair.
// Reset clears only the valid bits of the pipeline, so no result appears
// until a request has passed through. The receiver cannot stall, so the
// pipeline never holds.

module rect_overlap_push_vector_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_x_i,
  input  logic signed [15:0] first_y_i,
  input  logic [14:0]        first_w_i,
  input  logic [14:0]        first_h_i,
  input  logic [15:0]        first_angle_i,
  input  logic signed [15:0] second_x_i,
  input  logic signed [15:0] second_y_i,
  input  logic [14:0]        second_w_i,
  input  logic [14:0]        second_h_i,
  input  logic [15:0]        second_angle_i,
  output logic               done_o,
  output logic               overlap_o,
  output logic signed [15:0] push_x_o,
  output logic signed [15:0] push_y_o
);

  localparam int L   = rop_pkg::CORDIC_LAT;
  localparam int CW  = rop_pkg::CW;
  localparam int MW  = rop_pkg::MW;
  localparam int PW  = rop_pkg::PW;
  localparam int LW  = rop_pkg::LW;
  localparam int LOW = rop_pkg::LOW;
  localparam int TW  = rop_pkg::TW;
  localparam int PPW = TW + LW + 1;

  assign busy = 1'b0;

  // Request delay line alongside the CORDIC pipelines.
  rop_pkg::pair_t pay_q [0:L-1];
  logic           vld_q [0:L-1];
  rop_pkg::trig_t ca, sa, cb, sb;

  rop_cordic u_cordic_a (
    .clk_i   (clk_i),
    .angle_i (first_angle_i),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  rop_cordic u_cordic_b (
    .clk_i   (clk_i),
    .angle_i (second_angle_i),
    .cos_o   (cb),
    .sin_o   (sb)
  );

  always_ff @(posedge clk_i) begin
    pay_q[0] <= '{a: '{x: first_x_i, y: first_y_i, w: first_w_i, h: first_h_i},
                  b: '{x: second_x_i, y: second_y_i, w: second_w_i, h: second_h_i}};
    for (int i = 1; i < L; i++) begin
      pay_q[i] <= pay_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < L; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start;
      for (int i = 1; i < L; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Side information for stages one to six, valid bits for stages one to eight.
  rop_pkg::side_t side_q [1:6];
  logic           pv_q [1:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 8; i++) begin
        pv_q[i] <= 1'b0;
      end
    end else begin
      pv_q[1] <= vld_q[L-1];
      for (int i = 2; i <= 8; i++) begin
        pv_q[i] <= pv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[1] <= '{c: cb, s: sb,
                   use_w: pay_q[L-1].b.w != '0, use_h: pay_q[L-1].b.h != '0};
    for (int i = 2; i <= 6; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Stage 1: trig times half sizes, centers scaled to corner units.
  logic signed [rop_pkg::PRW-1:0] cw_q [2], sw_q [2], ch_q [2], sh_q [2];
  logic signed [rop_pkg::CTW-1:0] cx_q [2], cy_q [2];
  rop_pkg::rect_t                 rs [2];
  rop_pkg::trig_t                 rc [2], rsn [2];

  assign rs[0]  = pay_q[L-1].a;
  assign rs[1]  = pay_q[L-1].b;
  assign rc[0]  = ca;
  assign rc[1]  = cb;
  assign rsn[0] = sa;
  assign rsn[1] = sb;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      cw_q[r] <= rc[r]  * $signed({1'b0, rs[r].w});
      sw_q[r] <= rsn[r] * $signed({1'b0, rs[r].w});
      ch_q[r] <= rc[r]  * $signed({1'b0, rs[r].h});
      sh_q[r] <= rsn[r] * $signed({1'b0, rs[r].h});
      cx_q[r] <= $signed({rs[r].x, 15'b0});
      cy_q[r] <= $signed({rs[r].y, 15'b0});
    end
  end

  // Stage 2: corners in order (-w,-h), (w,-h), (w,h), (-w,h).
  logic signed [CW-1:0] px_q [2][4], py_q [2][4];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      for (int k = 0; k < 4; k++) begin
        if (k == 1 || k == 2) begin
          if (k >= 2) begin
            px_q[r][k] <= CW'(cx_q[r]) + CW'(cw_q[r]) - CW'(sh_q[r]);
            py_q[r][k] <= CW'(cy_q[r]) + CW'(sw_q[r]) + CW'(ch_q[r]);
          end else begin
            px_q[r][k] <= CW'(cx_q[r]) + CW'(cw_q[r]) + CW'(sh_q[r]);
            py_q[r][k] <= CW'(cy_q[r]) + CW'(sw_q[r]) - CW'(ch_q[r]);
          end
        end else begin
          if (k >= 2) begin
            px_q[r][k] <= CW'(cx_q[r]) - CW'(cw_q[r]) - CW'(sh_q[r]);
            py_q[r][k] <= CW'(cy_q[r]) - CW'(sw_q[r]) + CW'(ch_q[r]);
          end else begin
            px_q[r][k] <= CW'(cx_q[r]) - CW'(cw_q[r]) + CW'(sh_q[r]);
            py_q[r][k] <= CW'(cy_q[r]) - CW'(sw_q[r]) - CW'(ch_q[r]);
          end
        end
      end
    end
  end

  // Stage 3: corner times normal. Axes two and three are the negatives of
  // axes zero and one, so only the first two are projected.
  logic signed [MW-1:0] mx_q [2][2][4], my_q [2][2][4];
  rop_pkg::trig_t       nx2 [2], ny2 [2];

  assign nx2[0] = -side_q[2].s;
  assign ny2[0] = side_q[2].c;
  assign nx2[1] = -side_q[2].c;
  assign ny2[1] = -side_q[2].s;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 4; k++) begin
          mx_q[r][j][k] <= px_q[r][k] * nx2[j];
          my_q[r][j][k] <= py_q[r][k] * ny2[j];
        end
      end
    end
  end

  // Stage 4: projections.
  logic signed [PW-1:0] d_q [2][2][4];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 4; k++) begin
          d_q[r][j][k] <= PW'(mx_q[r][j][k]) + PW'(my_q[r][j][k]);
        end
      end
    end
  end

  // Stage 5: projection bounds on all four axes.
  logic signed [PW-1:0] lo_q [2][4], hi_q [2][4];
  logic signed [PW-1:0] lo_c [2][2], hi_c [2][2];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 2; j++) begin
        lo_c[r][j] = d_q[r][j][0];
        hi_c[r][j] = d_q[r][j][0];
        for (int k = 1; k < 4; k++) begin
          if (d_q[r][j][k] < lo_c[r][j]) begin
            lo_c[r][j] = d_q[r][j][k];
          end
          if (d_q[r][j][k] > hi_c[r][j]) begin
            hi_c[r][j] = d_q[r][j][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 2; r++) begin
      for (int j = 0; j < 2; j++) begin
        lo_q[r][j]   <= lo_c[r][j];
        hi_q[r][j]   <= hi_c[r][j];
        lo_q[r][j+2] <= -hi_c[r][j];
        hi_q[r][j+2] <= -lo_c[r][j];
      end
    end
  end

  // Stage 6: separation and signed overlap per axis.
  logic                 sep_q [4];
  logic signed [LW-1:0] len_q [4], mag_q [4];
  logic signed [LW-1:0] dab [4], dba [4], aab [4], aba [4];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      dab[a] = LW'(hi_q[1][a]) - LW'(lo_q[0][a]);
      dba[a] = LW'(hi_q[0][a]) - LW'(lo_q[1][a]);
      aab[a] = dab[a] < 0 ? -dab[a] : dab[a];
      aba[a] = dba[a] < 0 ? -dba[a] : dba[a];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 4; a++) begin
      sep_q[a] <= (lo_q[1][a] > hi_q[0][a]) || (lo_q[0][a] > hi_q[1][a]);
      if (aab[a] > aba[a]) begin
        len_q[a] <= -dba[a];
        mag_q[a] <= aba[a];
      end else begin
        len_q[a] <= dab[a];
        mag_q[a] <= aab[a];
      end
    end
  end

  // Stage 7: pick the first usable axis with the smallest overlap magnitude.
  logic                 ovl_q, have_q;
  logic signed [LW-1:0] blen_q;
  rop_pkg::trig_t       bnx_q, bny_q;
  logic                 ovl_c, have_c, usable;
  logic signed [LW-1:0] blen_c, bmag_c;
  rop_pkg::trig_t       bnx_c, bny_c, anx, any_n;

  always_comb begin
    ovl_c  = 1'b1;
    have_c = 1'b0;
    blen_c = '0;
    bmag_c = '0;
    bnx_c  = '0;
    bny_c  = '0;
    anx    = '0;
    any_n  = '0;
    usable = 1'b0;
    for (int a = 0; a < 4; a++) begin
      usable = (a % 2 == 1) ? side_q[6].use_h : side_q[6].use_w;
      case (a)
        0: begin
          anx   = -side_q[6].s;
          any_n = side_q[6].c;
        end
        1: begin
          anx   = -side_q[6].c;
          any_n = -side_q[6].s;
        end
        2: begin
          anx   = side_q[6].s;
          any_n = -side_q[6].c;
        end
        default: begin
          anx   = side_q[6].c;
          any_n = side_q[6].s;
        end
      endcase
      if (usable) begin
        if (sep_q[a]) begin
          ovl_c = 1'b0;
        end
        if (!have_c || bmag_c > mag_q[a]) begin
          have_c = 1'b1;
          blen_c = len_q[a];
          bmag_c = mag_q[a];
          bnx_c  = anx;
          bny_c  = any_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ovl_q  <= ovl_c;
    have_q <= have_c;
    blen_q <= blen_c;
    bnx_q  <= bnx_c;
    bny_q  <= bny_c;
  end

  // Stage 8: normal times overlap as two partial products.
  logic signed [TW+LW-LOW-1:0] ppxh_q, ppyh_q;
  logic signed [TW+LOW:0]      ppxl_q, ppyl_q;
  logic                        ovl8_q, have8_q;
  logic signed [LW-LOW-1:0]    len_hi;
  logic signed [LOW:0]         len_lo;

  assign len_hi = blen_q[LW-1:LOW];
  assign len_lo = $signed({1'b0, blen_q[LOW-1:0]});

  always_ff @(posedge clk_i) begin
    ppxh_q  <= bnx_q * len_hi;
    ppyh_q  <= bny_q * len_hi;
    ppxl_q  <= bnx_q * len_lo;
    ppyl_q  <= bny_q * len_lo;
    ovl8_q  <= ovl_q;
    have8_q <= have_q;
  end

  // Stage 9: combine, round half up, saturate.
  localparam int OUT_SHIFT_W = rop_pkg::OUT_SHIFT;
  localparam logic signed [PPW-1:0] RND = PPW'(1) <<< (OUT_SHIFT_W - 1);
  logic signed [PPW-1:0]           pxs, pys;
  logic signed [PPW-OUT_SHIFT_W:0] rx, ry;

  assign pxs = (PPW'(ppxh_q) <<< LOW) + PPW'(ppxl_q) + RND;
  assign pys = (PPW'(ppyh_q) <<< LOW) + PPW'(ppyl_q) + RND;
  assign rx  = $signed(pxs[PPW-1:OUT_SHIFT_W-1]) >>> 1;
  assign ry  = $signed(pys[PPW-1:OUT_SHIFT_W-1]) >>> 1;

  function automatic logic signed [15:0] sat16(input logic signed [PPW-OUT_SHIFT_W:0] v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7FFF;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic               done_q, overlap_q;
  logic signed [15:0] push_x_q, push_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pv_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= ovl8_q;
    if (!ovl8_q) begin
      push_x_q <= '0;
      push_y_q <= '0;
    end else if (!have8_q) begin
      push_x_q <= 16'sh7FFF;
      push_y_q <= 16'sh7FFF;
    end else begin
      push_x_q <= sat16(rx);
      push_y_q <= sat16(ry);
    end
  end

  assign done_o    = done_q;
  assign overlap_o = overlap_q;
  assign push_x_o  = push_x_q;
  assign push_y_o  = push_y_q;

endmodule

// File: tb/rop_push_checker.sv
// Checker for the rectangle overlap push vector unit: predicts each result from
// the accepted request and compares it with the result ports. Depends on nothing.
`timescale 1ns / 1ps

module rop_push_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [15:0] first_x_i,
  input  logic signed [15:0] first_y_i,
  input  logic [14:0]        first_w_i,
  input  logic [14:0]        first_h_i,
  input  logic [15:0]        first_angle_i,
  input  logic signed [15:0] second_x_i,
  input  logic signed [15:0] second_y_i,
  input  logic [14:0]        second_w_i,
  input  logic [14:0]        second_h_i,
  input  logic [15:0]        second_angle_i,
  input  logic               done_i,
  input  logic               overlap_i,
  input  logic signed [15:0] push_x_i,
  input  logic signed [15:0] push_y_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic               overlap;
    logic signed [15:0] push_x;
    logic signed [15:0] push_y;
  } push_t;

  localparam longint TrigOne = 16384;
  localparam longint OutShift = 43;

  push_t push_queue[$];
  int fails = 0;
  int pending_cnt = 0;

  assign fail_count_o = fails;
  assign pending_o = pending_cnt;

  // Quadrant plus residual CORDIC in Q1.14, matching the block's rotation.
  function automatic void sin_cos(input logic [15:0] ang, output longint co,
                                  output longint si);
    longint steps[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                          10, 5, 3, 1};
    logic [15:0] t;
    longint x, y, z, dx, dy;
    t = ang + 16'd8192;
    x = 9949;
    y = 0;
    z = longint'(t[13:0]) - 8192;
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= steps[i];
      end else begin
        x += dx; y -= dy; z += steps[i];
      end
    end
    case (t[15:14])
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic void rect_corners(input longint cx, input longint cy,
                                       input longint w, input longint h,
                                       input logic [15:0] ang,
                                       output longint px[4], output longint py[4]);
    longint c, s, lx, ly;
    sin_cos(ang, c, s);
    for (int k = 0; k < 4; k++) begin
      lx = (k == 0 || k == 3) ? -w : w;
      ly = (k < 2) ? -h : h;
      px[k] = cx * 2 * TrigOne + c * lx - s * ly;
      py[k] = cy * 2 * TrigOne + s * lx + c * ly;
    end
  endfunction

  function automatic void span(input longint px[4], input longint py[4],
                               input longint nx, input longint ny,
                               output longint lo, output longint hi);
    longint d;
    for (int k = 0; k < 4; k++) begin
      d = px[k] * nx + py[k] * ny;
      if (k == 0 || d < lo) lo = d;
      if (k == 0 || d > hi) hi = d;
    end
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [15:0] round_sat(input longint p);
    longint r;
    r = (p + (longint'(1) <<< (OutShift - 1))) >>> OutShift;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic push_t predict_push();
    longint ax[4], ay[4], bx[4], by[4];
    longint nx[4], ny[4];
    longint c, s, loa, hia, lob, hib, len, best_len, best_nx, best_ny;
    bit have, usable;
    push_t r;
    rect_corners(first_x_i, first_y_i, first_w_i, first_h_i, first_angle_i, ax, ay);
    rect_corners(second_x_i, second_y_i, second_w_i, second_h_i, second_angle_i,
                 bx, by);
    sin_cos(second_angle_i, c, s);
    nx = '{-s, -c, s, c};
    ny = '{c, -s, -c, s};
    have = 0;
    best_len = 0; best_nx = 0; best_ny = 0;
    for (int k = 0; k < 4; k++) begin
      usable = k[0] ? (second_h_i != 0) : (second_w_i != 0);
      if (usable) begin
        span(ax, ay, nx[k], ny[k], loa, hia);
        span(bx, by, nx[k], ny[k], lob, hib);
        // Equal bounds touch and still count as overlap.
        if (lob > hia || loa > hib) return '0;
        len = (mag(hib - loa) > mag(hia - lob)) ? lob - hia : hib - loa;
        if (!have || mag(best_len) > mag(len)) begin
          have = 1;
          best_len = len;
          best_nx = nx[k];
          best_ny = ny[k];
        end
      end
    end
    r.overlap = 1'b1;
    if (!have) begin
      r.push_x = 16'sd32767;
      r.push_y = 16'sd32767;
    end else begin
      r.push_x = round_sat(best_nx * best_len);
      r.push_y = round_sat(best_ny * best_len);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    push_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (push_queue.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = push_queue.pop_front();
          if (overlap_i !== want.overlap) begin
            $error("overlap: expected %0d, got %0d", want.overlap, overlap_i);
            fails++;
          end
          if (push_x_i !== want.push_x) begin
            $error("push_x: expected %0d, got %0d", want.push_x, push_x_i);
            fails++;
          end
          if (push_y_i !== want.push_y) begin
            $error("push_y: expected %0d, got %0d", want.push_y, push_y_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) push_queue.push_back(predict_push());
    end
    pending_cnt = push_queue.size();
  end

endmodule

// File: tb/tb_rect_overlap_push_vector_unit.sv
// Testbench top for rect_overlap_push_vector_unit: drives directed and random
// rectangle pairs in bursts. Depends on rop_push_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_rect_overlap_push_vector_unit;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] first_x_i = '0, first_y_i = '0;
  logic [14:0]        first_w_i = '0, first_h_i = '0;
  logic [15:0]        first_angle_i = '0;
  logic signed [15:0] second_x_i = '0, second_y_i = '0;
  logic [14:0]        second_w_i = '0, second_h_i = '0;
  logic [15:0]        second_angle_i = '0;
  logic               done_o, overlap_o;
  logic signed [15:0] push_x_o, push_y_o;
  int                 fail_count, pending;

  rect_overlap_push_vector_unit i_dut (.*);

  rop_push_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .first_x_i, .first_y_i, .first_w_i, .first_h_i, .first_angle_i,
    .second_x_i, .second_y_i, .second_w_i, .second_h_i, .second_angle_i,
    .done_i(done_o), .overlap_i(overlap_o), .push_x_i(push_x_o),
    .push_y_i(push_y_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  int burst_left = 0;

  // Holds start high from the falling edge until the request is taken.
  task automatic send_pair(input logic [15:0] ax, ay, input logic [14:0] aw, ah,
                           input logic [15:0] aa, input logic [15:0] bx, by,
                           input logic [14:0] bw, bh, input logic [15:0] ba);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    first_x_i = ax; first_y_i = ay; first_w_i = aw; first_h_i = ah;
    first_angle_i = aa;
    second_x_i = bx; second_y_i = by; second_w_i = bw; second_h_i = bh;
    second_angle_i = ba;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_random();
    logic [15:0] cx, cy, dx, dy;
    int mode;
    mode = $urandom_range(0, 9);
    cx = 16'($urandom);
    cy = 16'($urandom);
    if (mode < 7) begin
      // Close centers and moderate sizes so that most pairs overlap.
      dx = 16'($urandom_range(0, 1600)) - 16'd800;
      dy = 16'($urandom_range(0, 1600)) - 16'd800;
      send_pair(cx, cy, 15'($urandom_range(0, 1200)), 15'($urandom_range(0, 1200)),
                16'($urandom), cx + dx, cy + dy, 15'($urandom_range(0, 1200)),
                15'($urandom_range(0, 1200)), 16'($urandom));
    end else if (mode < 9) begin
      send_pair(cx, cy, 15'($urandom), 15'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    end else begin
      // Huge rectangles near each other push the output into saturation.
      send_pair(cx, cy, 15'($urandom_range(16000, 32767)),
                15'($urandom_range(16000, 32767)), 16'($urandom),
                cx + 16'($urandom_range(0, 255)), cy, 15'($urandom_range(0, 32767)),
                15'($urandom_range(0, 32767)), 16'($urandom));
    end
  endtask

  initial begin
    int cycles;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pair(16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF, 16'hFFFF,
              16'sh8000, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 16'h0000);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 32, 32, 0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 32, 32, 0, 0, 0, 0, 64, 16'h2000);
    send_pair(0, 0, 32, 32, 0, 0, 0, 64, 0, 16'h1000);
    // Edges that only touch on an axis.
    send_pair(0, 0, 32, 32, 0, 32, 0, 32, 32, 0);
    send_pair(0, 0, 32, 32, 0, 33, 0, 32, 32, 0);
    send_pair(0, 0, 32, 32, 0, 0, 32, 32, 32, 16'h4000);
    // Identical squares make all four axes tie.
    send_pair(100, 100, 64, 64, 0, 100, 100, 64, 64, 0);
    send_pair(0, 0, 64, 64, 16'h2000, 0, 0, 64, 64, 16'h8000);
    send_pair(0, 0, 64, 16, 16'hC000, 8, -8, 64, 16, 16'hC000);
    send_pair(0, 0, 0, 0, 0, 5, 5, 64, 64, 16'h1FFF);
    send_pair(0, 0, 200, 0, 16'h6000, 5, 5, 64, 64, 16'hE000);
    send_pair(16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 0, 16'sh7FFF, 16'sh7FFF,
              15'h7FFF, 15'h7FFF, 16'hA000);
    send_pair(16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF, 16'h7FFF,
              16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 16'h8001);
    send_pair(-40, 20, 100, 50, 16'h0400, -10, 0, 80, 40, 16'hFC00);

    for (int n = 0; n < 1400; n++) begin
      send_random();
      if (n == 700) begin
        start = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    start = 1'b0;

    cycles = 0;
    while (pending != 0 && cycles < 10000) begin
      @(negedge clk_i);
      cycles++;
    end
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
